### design/llsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// llsp_pkg
// Shared types and constants for the least-load server picker.
// ----------------------------------------------------------------------------
package llsp_pkg;

    localparam int unsigned MAX_SERVERS = 64;
    localparam int unsigned MAX_PENDING = 8;
    localparam int unsigned SID_W  = $clog2(MAX_SERVERS);
    localparam int unsigned PTR_W  = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
    localparam int unsigned FILL_W = $clog2(MAX_PENDING + 1);
    localparam int unsigned COST_W = 17;
    localparam int unsigned LIFE_W = 20;
    localparam logic [LIFE_W-1:0] LIFE_RESET = 20'd1000;
    localparam logic [LIFE_W-1:0] LIFE_MAX   = 20'd1000000;

    typedef enum logic [1:0] {
        KIND_ON      = 2'd0,
        KIND_OFF     = 2'd1,
        KIND_REPORT  = 2'd2,
        KIND_REQUEST = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_REJECT   = 2'd1,
        ST_NOSERVER = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  server_id;
        logic [15:0] client_count;
        logic [31:0] now;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] chosen_server;
        logic       reservation_dropped;
    } rsp_t;

endpackage
`default_nettype wire

### design/least_load_server_picker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// least_load_server_picker
// A client request scans every server slot one per cycle through the slot
// memory. A load report also pops each expired reservation from the head
// of that server's queue in turn. One request is in work at a time; the
// result register lets the next request enter while a result still waits.
// Slot state lives in a registered-read memory (load, head, fill) and a
// second memory of expiry times; valid bits sit in flip-flops cleared by
// reset.
// ----------------------------------------------------------------------------
module least_load_server_picker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire llsp_pkg::req_t    in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output llsp_pkg::rsp_t         out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [1:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int unsigned SW = llsp_pkg::SID_W;
    localparam int unsigned PW = llsp_pkg::PTR_W;
    localparam int unsigned FW = llsp_pkg::FILL_W;
    localparam int unsigned CW = llsp_pkg::COST_W;
    localparam int unsigned LW = llsp_pkg::LIFE_W;
    localparam int unsigned EA = SW + PW;
    localparam int unsigned SMW = 16 + PW + FW;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_PICK, S_RPT_RD, S_RPT_CHK, S_DONE
    } state_t;

    state_t                 state_reg;
    llsp_pkg::req_t         req_reg;
    logic [LW-1:0]          life_reg;
    logic [llsp_pkg::MAX_SERVERS-1:0] valid_reg;
    logic [SW:0]            scan_reg;
    logic                   found_reg;
    logic [SW-1:0]          best_reg;
    logic [CW-1:0]          best_cost_reg;
    logic [15:0]            ld_reg;
    logic [PW-1:0]          hd_reg;
    logic [FW-1:0]          fl_reg;
    logic                   out_valid_reg;
    llsp_pkg::rsp_t         out_reg;
    llsp_pkg::rsp_t         rsp_reg;

    logic [SMW-1:0]         smem [llsp_pkg::MAX_SERVERS];
    logic [31:0]            emem [llsp_pkg::MAX_SERVERS * llsp_pkg::MAX_PENDING];

    logic                   s_we;
    logic [SW-1:0]          s_waddr;
    logic [SMW-1:0]         s_wdata;
    logic [SW-1:0]          s_raddr;
    logic [SMW-1:0]         s_rdata_reg;
    logic                   e_we;
    logic [EA-1:0]          e_waddr;
    logic [31:0]            e_wdata;
    logic [EA-1:0]          e_raddr;
    logic [31:0]            e_rdata_reg;

    logic [15:0]            r_ld;
    logic [PW-1:0]          r_hd;
    logic [FW-1:0]          r_fl;
    logic [CW-1:0]          r_cost;
    logic [SW-1:0]          prev_slot;
    logic                   prev_valid;
    logic                   take;
    logic [31:0]            diff;
    logic                   expired;
    logic [PW-1:0]          hd_inc;
    logic [PW-1:0]          tail;
    logic [LW-1:0]          wr_life;

    assign r_ld = s_rdata_reg[SMW-1 -: 16];
    assign r_hd = s_rdata_reg[FW +: PW];
    assign r_fl = s_rdata_reg[FW-1:0];
    assign r_cost = CW'(r_ld) + CW'(r_fl);
    assign prev_slot = SW'(scan_reg - 1'b1);
    assign prev_valid = valid_reg[prev_slot];
    assign take = (scan_reg != '0) && prev_valid && (!found_reg || r_cost < best_cost_reg);
    assign diff = e_rdata_reg - req_reg.now;
    assign expired = (diff == 32'd0) || diff[31];
    assign hd_inc = (llsp_pkg::MAX_PENDING == 1) ? PW'(0)
                  : PW'((32'(hd_reg) + 1) % llsp_pkg::MAX_PENDING);
    assign tail = PW'((32'(r_hd) + 32'(r_fl)) % llsp_pkg::MAX_PENDING);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign pready    = 1'b1;
    assign prdata    = 32'(life_reg);

    always_comb
    begin
        wr_life = pwdata[LW-1:0];
        if (wr_life == '0)
            wr_life = LW'(1);
        else if (wr_life > llsp_pkg::LIFE_MAX)
            wr_life = llsp_pkg::LIFE_MAX;
    end

    always_comb
    begin
        s_raddr = SW'(scan_reg);
        e_raddr = {req_reg.server_id, hd_reg};
        s_we = 1'b0;
        s_waddr = req_reg.server_id;
        s_wdata = {ld_reg, hd_reg, fl_reg};
        e_we = 1'b0;
        e_waddr = {best_reg, tail};
        e_wdata = req_reg.now + 32'(life_reg);
        if (state_reg == S_IDLE)
        begin
            s_raddr = in_data.server_id;
        end
        else if (state_reg == S_SCAN && scan_reg[SW])
        begin
            s_raddr = take ? prev_slot : best_reg;
        end
        if (state_reg == S_RPT_RD)
        begin
            e_raddr = {req_reg.server_id, r_hd};
        end
        if (state_reg == S_PICK && found_reg && r_fl < FW'(llsp_pkg::MAX_PENDING))
        begin
            s_we = 1'b1;
            s_waddr = best_reg;
            s_wdata = {r_ld, r_hd, FW'(r_fl + 1'b1)};
            e_we = 1'b1;
        end
        if (state_reg == S_RPT_CHK && (fl_reg == '0 || !expired))
        begin
            s_we = 1'b1;
        end
        if (state_reg == S_RPT_CHK && fl_reg != '0 && expired)
        begin
            e_raddr = {req_reg.server_id, hd_inc};
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
            smem[s_waddr] <= s_wdata;
        s_rdata_reg <= smem[s_raddr];
        if (e_we)
            emem[e_waddr] <= e_wdata;
        e_rdata_reg <= emem[e_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            life_reg      <= llsp_pkg::LIFE_RESET;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            scan_reg      <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr == 2'd0)
                life_reg <= wr_life;
            if (state_reg == S_DONE && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg <= in_data;
                        unique case (llsp_pkg::kind_t'(in_data.kind))
                            llsp_pkg::KIND_REQUEST:
                            begin
                                state_reg <= S_SCAN;
                                scan_reg  <= '0;
                                found_reg <= 1'b0;
                            end
                            llsp_pkg::KIND_ON:
                            begin
                                rsp_reg <= '{
                                    status: valid_reg[in_data.server_id]
                                            ? llsp_pkg::ST_REJECT : llsp_pkg::ST_OK,
                                    chosen_server: '0,
                                    reservation_dropped: 1'b0};
                                if (!valid_reg[in_data.server_id])
                                begin
                                    valid_reg[in_data.server_id] <= 1'b1;
                                    ld_reg <= '0;
                                    hd_reg <= '0;
                                    fl_reg <= '0;
                                end
                                state_reg <= valid_reg[in_data.server_id] ? S_DONE
                                                                        : S_RPT_CHK;
                            end
                            llsp_pkg::KIND_OFF:
                            begin
                                rsp_reg <= '{
                                    status: valid_reg[in_data.server_id]
                                            ? llsp_pkg::ST_OK : llsp_pkg::ST_REJECT,
                                    chosen_server: '0,
                                    reservation_dropped: 1'b0};
                                if (valid_reg[in_data.server_id])
                                    valid_reg[in_data.server_id] <= 1'b0;
                                state_reg <= S_DONE;
                            end
                            default:
                            begin
                                rsp_reg <= '{
                                    status: valid_reg[in_data.server_id]
                                            ? llsp_pkg::ST_OK : llsp_pkg::ST_REJECT,
                                    chosen_server: '0,
                                    reservation_dropped: 1'b0};
                                state_reg <= valid_reg[in_data.server_id] ? S_RPT_RD
                                                                        : S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (take)
                    begin
                        found_reg     <= 1'b1;
                        best_reg      <= prev_slot;
                        best_cost_reg <= r_cost;
                    end
                    if (scan_reg[SW])
                        state_reg <= S_PICK;
                    else
                        scan_reg <= scan_reg + 1'b1;
                end
                S_PICK:
                begin
                    rsp_reg <= '{
                        status: found_reg ? llsp_pkg::ST_OK : llsp_pkg::ST_NOSERVER,
                        chosen_server: found_reg ? best_reg : '0,
                        reservation_dropped: found_reg &&
                                             (r_fl >= FW'(llsp_pkg::MAX_PENDING))};
                    state_reg <= S_DONE;
                end
                S_RPT_RD:
                begin
                    ld_reg <= req_reg.client_count;
                    hd_reg <= r_hd;
                    fl_reg <= r_fl;
                    state_reg <= S_RPT_CHK;
                end
                S_RPT_CHK:
                begin
                    if (fl_reg != '0 && expired)
                    begin
                        hd_reg <= hd_inc;
                        fl_reg <= fl_reg - 1'b1;
                    end
                    else
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_reg <= rsp_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_life_range: assert property (@(posedge clk) disable iff (!rst_n)
        life_reg != '0 && life_reg <= llsp_pkg::LIFE_MAX)
        else $error("lifetime out of range");
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RPT_CHK |-> fl_reg <= FW'(llsp_pkg::MAX_PENDING))
        else $error("fill out of range");
    a_pick_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PICK && found_reg |-> valid_reg[best_reg])
        else $error("picked invalid server");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && out_valid_reg && !out_ready |=> out_valid_reg)
        else $error("result lost");
`endif

endmodule
`default_nettype wire

### tb/sv/least_load_server_picker_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// least_load_server_picker_test
// Drives server registration, load reports and client requests into the
// least-load server picker with random idle gaps on both sides. A scoreboard
// tracks the server table, predicts each response and compares it in order.
// ----------------------------------------------------------------------------
module least_load_server_picker_test;

    class picker_scoreboard;
        bit          srv_on [64];
        bit [15:0]   load [64];
        bit [31:0]   expiry [64][8];
        bit [2:0]    head [64];
        bit [3:0]    fill [64];
        bit [19:0]   lifetime;
        llsp_pkg::rsp_t pending_rsp [$];
        int          errors;
        int          checked;

        function void clear_table();
            for (int s = 0; s < 64; s++)
            begin
                srv_on[s] = 0;
                load[s] = 0;
                head[s] = 0;
                fill[s] = 0;
            end
            lifetime = llsp_pkg::LIFE_RESET;
        endfunction

        function void set_lifetime(bit [31:0] v);
            bit [19:0] w;
            w = v[19:0];
            if (w == 0)
                w = 1;
            if (w > llsp_pkg::LIFE_MAX)
                w = llsp_pkg::LIFE_MAX;
            lifetime = w;
        endfunction

        function bit is_stale(bit [31:0] e, bit [31:0] t);
            bit [31:0] d;
            d = e - t;
            return (d == 0) || d[31];
        endfunction

        function void note_request(llsp_pkg::req_t r);
            llsp_pkg::rsp_t o;
            int best;
            int best_cost;
            int c;
            o = '0;
            best = -1;
            best_cost = 0;
            if (r.kind == llsp_pkg::KIND_REQUEST)
            begin
                for (int s = 0; s < 64; s++)
                begin
                    if (!srv_on[s])
                        continue;
                    c = load[s] + fill[s];
                    if (best < 0 || c < best_cost)
                    begin
                        best = s;
                        best_cost = c;
                    end
                end
                if (best < 0)
                    o.status = llsp_pkg::ST_NOSERVER;
                else
                begin
                    o.chosen_server = 6'(best);
                    if (fill[best] >= 8)
                        o.reservation_dropped = 1;
                    else
                    begin
                        expiry[best][3'(head[best] + fill[best])] = r.now + lifetime;
                        fill[best]++;
                    end
                end
            end
            else if (r.kind == llsp_pkg::KIND_ON)
            begin
                if (srv_on[r.server_id])
                    o.status = llsp_pkg::ST_REJECT;
                else
                begin
                    srv_on[r.server_id] = 1;
                    load[r.server_id] = 0;
                    head[r.server_id] = 0;
                    fill[r.server_id] = 0;
                end
            end
            else if (!srv_on[r.server_id])
                o.status = llsp_pkg::ST_REJECT;
            else if (r.kind == llsp_pkg::KIND_OFF)
                srv_on[r.server_id] = 0;
            else
            begin
                load[r.server_id] = r.client_count;
                while (fill[r.server_id] > 0 &&
                       is_stale(expiry[r.server_id][head[r.server_id]], r.now))
                begin
                    head[r.server_id]++;
                    fill[r.server_id]--;
                end
            end
            pending_rsp.push_back(o);
        endfunction

        function void check_response(llsp_pkg::rsp_t got);
            llsp_pkg::rsp_t exp_rsp;
            checked++;
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected response %h", $time, got);
                errors++;
                return;
            end
            exp_rsp = pending_rsp.pop_front();
            if (got.status != exp_rsp.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time,
                         exp_rsp.status, got.status);
                errors++;
            end
            if (got.chosen_server != exp_rsp.chosen_server)
            begin
                $display("%0t: chosen_server expected %0d actual %0d", $time,
                         exp_rsp.chosen_server, got.chosen_server);
                errors++;
            end
            if (got.reservation_dropped != exp_rsp.reservation_dropped)
            begin
                $display("%0t: reservation_dropped expected %0d actual %0d", $time,
                         exp_rsp.reservation_dropped, got.reservation_dropped);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    llsp_pkg::req_t in_data;
    logic        out_valid;
    logic        out_ready;
    llsp_pkg::rsp_t out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    picker_scoreboard board;
    bit [31:0]        tick;
    int               sent;
    int               out_gap;

    least_load_server_picker i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    task automatic write_lifetime(bit [31:0] v);
        @(negedge clk);
        psel <= 1;
        pwrite <= 1;
        paddr <= 2'd0;
        pwdata <= v;
        @(negedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        board.set_lifetime(v);
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic send_request(bit [1:0] k, bit [5:0] sid, bit [15:0] cnt, bit [31:0] t);
        llsp_pkg::req_t r;
        int gap;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap)
                @(negedge clk);
        end
        r.kind = k;
        r.server_id = sid;
        r.client_count = cnt;
        r.now = t;
        in_data <= r;
        in_valid <= 1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_request(r);
        sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.pending_rsp.size() != 0)
            @(negedge clk);
        repeat (100)
            @(negedge clk);
    endtask

    task automatic random_phase(int count, int id_span);
        int roll;
        bit [5:0] sid;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            sid = 6'($urandom_range(0, id_span));
            tick = tick + $urandom_range(0, 400);
            if ($urandom_range(0, 40) == 0)
                tick = $urandom;
            if (roll < 12)
                send_request(llsp_pkg::KIND_ON, sid, 16'($urandom), tick);
            else if (roll < 18)
                send_request(llsp_pkg::KIND_OFF, sid, 16'($urandom), tick);
            else if (roll < 40)
                send_request(llsp_pkg::KIND_REPORT, sid,
                             16'(($urandom_range(0, 7) == 0) ? $urandom
                                                             : $urandom_range(0, 12)),
                             tick);
            else
                send_request(llsp_pkg::KIND_REQUEST, 6'($urandom), 16'($urandom), tick);
        end
    endtask

    initial
    begin
        out_ready = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            out_gap = $urandom_range(0, 10);
            if (out_gap > 0)
            begin
                out_ready <= 0;
                repeat (out_gap)
                    @(negedge clk);
            end
            out_ready <= 1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            board.check_response(out_data);

    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        board = new();
        board.clear_table();
        clk = 0;
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        tick = 32'hFFFF_FF00;
        repeat (10)
            @(negedge clk);
        rst_n <= 1;

        send_request(llsp_pkg::KIND_REQUEST, 6'd0, 16'd0, tick);
        send_request(llsp_pkg::KIND_OFF, 6'd63, 16'hFFFF, tick);
        send_request(llsp_pkg::KIND_REPORT, 6'd5, 16'd1, tick);
        send_request(llsp_pkg::KIND_ON, 6'd0, 16'd0, tick);
        send_request(llsp_pkg::KIND_ON, 6'd63, 16'hFFFF, tick);
        send_request(llsp_pkg::KIND_ON, 6'd63, 16'd0, tick);
        send_request(llsp_pkg::KIND_REPORT, 6'd0, 16'hFFFF, tick);
        for (int i = 0; i < 10; i++)
            send_request(llsp_pkg::KIND_REQUEST, 6'h3F, 16'hFFFF, tick + i);
        send_request(llsp_pkg::KIND_REPORT, 6'd63, 16'd0, tick + 32'd1003);
        send_request(llsp_pkg::KIND_REPORT, 6'd63, 16'd0, tick + 32'd1200);
        send_request(llsp_pkg::KIND_REQUEST, 6'd0, 16'd0, 32'hFFFF_FFFF);
        send_request(llsp_pkg::KIND_OFF, 6'd63, 16'd0, tick);
        send_request(llsp_pkg::KIND_OFF, 6'd0, 16'd0, tick);
        send_request(llsp_pkg::KIND_REQUEST, 6'd0, 16'd0, 32'd0);
        drain();

        write_lifetime(32'd0);
        random_phase(150, 7);
        drain();
        write_lifetime(32'hFFFF_FFFF);
        random_phase(150, 63);
        drain();
        write_lifetime(32'd1000000);
        random_phase(150, 15);
        drain();
        write_lifetime($urandom_range(2, 3000));
        random_phase(150, 5);
        drain();
        write_lifetime(32'd1);
        random_phase(150, 3);
        drain();

        $display("Covered %0d requests over five lifetime settings; %0d responses checked.",
                 sent, board.checked);
        if (board.errors == 0 && board.pending_rsp.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

### filelist.f
design/llsp_pkg.sv
design/least_load_server_picker.sv
tb/sv/least_load_server_picker_test.sv
